// ===== src/ate_pkg.sv =====
// ---------------------------------------------------------------------------
// ate_pkg: shared types, codes and helpers of the affine transform engine
// Word and matrix types, operation codes and the saturation functions.
// ---------------------------------------------------------------------------
`default_nettype none

package ate_pkg;

    // word and matrix geometry
    localparam int WORD_W        = 32;
    localparam int PROD_W        = 2 * WORD_W;
    localparam int SUM_W         = WORD_W + 2;
    localparam int DIM           = 4;
    localparam int ELEMS         = DIM * DIM;
    localparam int FRAC_BITS_DEF = 16;

    // stream widths
    localparam int S_TDATA_W = 136;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 96;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef word_t [ELEMS-1:0]        mat_t;
    typedef word_t [DIM-1:0]          vec_t;
    typedef prod_t [ELEMS-1:0]        prod_mat_t;

    // operation codes carried in tuser
    typedef enum logic [2:0] {
        KIND_WR_CUR    = 3'd0,
        KIND_WR_OPR    = 3'd1,
        KIND_COMPOSE   = 3'd2,
        KIND_TRANSLATE = 3'd3,
        KIND_POINT     = 3'd4
    } kind_t;

    // one accepted input beat
    typedef struct packed {
        kind_t       kind;
        logic [1:0]  row;
        logic [1:0]  col;
        word_t       value;
        word_t       px;
        word_t       py;
        word_t       pz;
    } item_t;

    // control of the product stage
    typedef struct packed {
        kind_t       kind;
        logic [1:0]  row;
        logic        use_prod3;
    } bctl_t;

    localparam word_t WORD_MAX = word_t'({1'b0, {(WORD_W-1){1'b1}}});
    localparam word_t WORD_MIN = word_t'({1'b1, {(WORD_W-1){1'b0}}});

    // clamp a rounded product to the word range
    function automatic word_t sat_prod(input prod_t v);
        word_t r;
        if (v > prod_t'(WORD_MAX))
            r = WORD_MAX;
        else if (v < prod_t'(WORD_MIN))
            r = WORD_MIN;
        else
            r = v[WORD_W-1:0];
        return r;
    endfunction

    // clamp a four-term sum to the word range
    function automatic word_t sat_sum(input sum_t v);
        word_t r;
        if (v > sum_t'(WORD_MAX))
            r = WORD_MAX;
        else if (v < sum_t'(WORD_MIN))
            r = WORD_MIN;
        else
            r = v[WORD_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/ate_mul_array.sv =====
// ---------------------------------------------------------------------------
// ate_mul_array: sixteen signed word multipliers with registered products
// Each lane forms the exact double-width product of its two operands.
// ---------------------------------------------------------------------------
`default_nettype none

module ate_mul_array
    import ate_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      en,
    input  wire mat_t      a,
    input  wire mat_t      b,
    output prod_mat_t      prod
);

    prod_mat_t prod_reg;
    prod_mat_t prod_next;

    // exact products, one per lane
    always_comb
    begin
        for (int p = 0; p < ELEMS; p++)
        begin
            prod_next[p] = prod_t'(a[p]) * prod_t'(b[p]);
        end
    end

    // product register, loaded when a beat enters the stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== src/ate_reduce.sv =====
// ---------------------------------------------------------------------------
// ate_reduce: rounding, saturation and column sums of the product array
// Rounds each product to nearest (ties up), saturates, adds four terms
// per column and saturates the total.
// ---------------------------------------------------------------------------
`default_nettype none

module ate_reduce
    import ate_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire prod_mat_t prod,
    input  wire vec_t      addend,
    input  wire bctl_t     ctl,
    output vec_t           sums
);

    localparam prod_t HALF = prod_t'(1) <<< (FRAC_BITS - 1);

    word_t rnd [ELEMS];
    sum_t  acc [DIM];

    // round and clamp every product
    always_comb
    begin
        for (int p = 0; p < ELEMS; p++)
        begin
            rnd[p] = sat_prod((prod[p] + HALF) >>> FRAC_BITS);
        end
    end

    // column sums: fourth term is a product for compose, the row-3 entry otherwise
    always_comb
    begin
        for (int j = 0; j < DIM; j++)
        begin
            acc[j] = sum_t'(rnd[j]) + sum_t'(rnd[DIM + j]) + sum_t'(rnd[2*DIM + j])
                   + (ctl.use_prod3 ? sum_t'(rnd[3*DIM + j]) : sum_t'(addend[j]));
            sums[j] = sat_sum(acc[j]);
        end
    end

endmodule

`default_nettype wire

// ===== src/affine_transform_engine_core.sv =====
// ---------------------------------------------------------------------------
// affine_transform_engine_core: 4x4 fixed-point vertex transform engine
// Holds a current and an operand matrix and applies element writes,
// compose, translate and point transforms from a beat stream.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries commands: tuser is the operation, tdata the row, column,
//   element value and x/y/z. m_axis carries one beat per point transform with
//   the transformed x/y/z; no other operation produces a beat.
//   A point beat shows on m_axis after it passes the input register, which
//   loads at the accepting edge, then the product register (sixteen
//   multipliers), then the result register. Point transforms and element
//   writes go at one beat per cycle while m_axis accepts and no write-back is
//   pending. Compose runs one result row per cycle through the multiplier array
//   while the product stage has room, and holds s_axis_tready low until its last
//   row issues. Translate and the last compose row write the current matrix back
//   from the product stage, and the beat after them waits for that write-back.
//   Reset loads both matrices with identity and empties all stages.
//   When m_axis stalls, the result register holds its beat, one more point
//   waits in the product stage, one in the input register, then
//   s_axis_tready drops.
// ---------------------------------------------------------------------------
`default_nettype none

module affine_transform_engine_core
    import ate_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // row[1:0], col[3:2], value[35:4], px[67:36], py[99:68], pz[131:100], zero pad
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    // kind[2:0]
    input  wire logic [S_TUSER_W-1:0] s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64]
    output logic [M_TDATA_W-1:0]      m_axis_tdata
);

    localparam word_t ONE = word_t'(1) <<< FRAC_BITS;

    // matrices
    mat_t  cur_reg;
    mat_t  opr_reg;
    word_t tmp_reg [3][DIM];

    // input stage
    logic       a_valid_reg;
    item_t      a_item_reg;
    logic [1:0] crow_reg;

    // product stage
    logic  b_valid_reg;
    bctl_t b_ctrl_reg;
    vec_t  b_add_reg;

    // result register
    logic  out_valid_reg;
    vec_t  out_data_reg;

    item_t     s_item;
    logic      hazard;
    logic      out_free;
    logic      b_go;
    logic      b_room;
    logic      a_needs_b;
    logic      a_issue;
    logic      a_done;
    logic      cur_wr_a;
    logic      cur_wr_b;
    mat_t      op_a;
    vec_t      add_next;
    prod_mat_t prod;
    vec_t      sums;

    // unpack the input beat
    always_comb
    begin
        s_item.kind  = kind_t'(s_axis_tuser[2:0]);
        s_item.row   = s_axis_tdata[1:0];
        s_item.col   = s_axis_tdata[3:2];
        s_item.value = s_axis_tdata[35:4];
        s_item.px    = s_axis_tdata[67:36];
        s_item.py    = s_axis_tdata[99:68];
        s_item.pz    = s_axis_tdata[131:100];
    end

    // stage handshakes and matrix write-back hazard
    always_comb
    begin
        hazard   = b_valid_reg && ((b_ctrl_reg.kind == KIND_TRANSLATE) ||
                   ((b_ctrl_reg.kind == KIND_COMPOSE) && (b_ctrl_reg.row == 2'd3)));
        out_free = !out_valid_reg || m_axis_tready;
        b_go     = b_valid_reg && ((b_ctrl_reg.kind != KIND_POINT) || out_free);
        b_room   = !b_valid_reg || b_go;
        case (a_item_reg.kind)
            KIND_COMPOSE, KIND_TRANSLATE, KIND_POINT: a_needs_b = 1'b1;
            default:                                  a_needs_b = 1'b0;
        endcase
        a_issue = a_valid_reg && a_needs_b && b_room && !hazard;
        if (a_needs_b)
            a_done = a_issue && ((a_item_reg.kind != KIND_COMPOSE) || (crow_reg == 2'd3));
        else
            a_done = a_valid_reg && !hazard;
        cur_wr_a = a_done && (a_item_reg.kind == KIND_WR_CUR);
        cur_wr_b = b_go && ((b_ctrl_reg.kind == KIND_TRANSLATE) ||
                   ((b_ctrl_reg.kind == KIND_COMPOSE) && (b_ctrl_reg.row == 2'd3)));
    end

    assign s_axis_tready = !a_valid_reg || a_done;

    // multiplier operands: operand row for compose, x/y/z otherwise
    always_comb
    begin
        for (int k = 0; k < DIM; k++)
        begin
            for (int j = 0; j < DIM; j++)
            begin
                if (a_item_reg.kind == KIND_COMPOSE)
                    op_a[k*DIM + j] = opr_reg[{crow_reg, 2'(k)}];
                else if (k == 0)
                    op_a[k*DIM + j] = a_item_reg.px;
                else if (k == 1)
                    op_a[k*DIM + j] = a_item_reg.py;
                else if (k == 2)
                    op_a[k*DIM + j] = a_item_reg.pz;
                else
                    op_a[k*DIM + j] = '0;
            end
        end
        for (int j = 0; j < DIM; j++)
        begin
            add_next[j] = (a_item_reg.kind == KIND_COMPOSE) ? '0 : cur_reg[3*DIM + j];
        end
    end

    ate_mul_array u_mul (
        .clk  (clk),
        .en   (a_issue),
        .a    (op_a),
        .b    (cur_reg),
        .prod (prod)
    );

    ate_reduce #(
        .FRAC_BITS (FRAC_BITS)
    ) u_reduce (
        .prod   (prod),
        .addend (b_add_reg),
        .ctl    (b_ctrl_reg),
        .sums   (sums)
    );

    // input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            crow_reg    <= 2'd0;
        end
        else
        begin
            if (s_axis_tready)
                a_valid_reg <= s_axis_tvalid;
            if (a_issue && (a_item_reg.kind == KIND_COMPOSE))
                crow_reg <= crow_reg + 2'd1;
        end
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            a_item_reg <= s_item;
    end

    // product stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (b_room)
            b_valid_reg <= a_issue;
    end

    // product stage payload
    always_ff @(posedge clk)
    begin
        if (a_issue)
        begin
            b_ctrl_reg.kind      <= a_item_reg.kind;
            b_ctrl_reg.row       <= crow_reg;
            b_ctrl_reg.use_prod3 <= (a_item_reg.kind == KIND_COMPOSE);
            b_add_reg            <= add_next;
        end
    end

    // current matrix: element writes and product-stage write-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ELEMS; i++)
                cur_reg[i] <= ((i % 5) == 0) ? ONE : '0;
        end
        else if (cur_wr_a)
        begin
            cur_reg[{a_item_reg.row, a_item_reg.col}] <= a_item_reg.value;
        end
        else if (cur_wr_b)
        begin
            if (b_ctrl_reg.kind == KIND_COMPOSE)
            begin
                for (int r = 0; r < 3; r++)
                    for (int j = 0; j < DIM; j++)
                        cur_reg[r*DIM + j] <= tmp_reg[r][j];
            end
            for (int j = 0; j < DIM; j++)
                cur_reg[3*DIM + j] <= sums[j];
        end
    end

    // operand matrix
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ELEMS; i++)
                opr_reg[i] <= ((i % 5) == 0) ? ONE : '0;
        end
        else if (a_done && (a_item_reg.kind == KIND_WR_OPR))
        begin
            opr_reg[{a_item_reg.row, a_item_reg.col}] <= a_item_reg.value;
        end
    end

    // compose rows 0 to 2 wait here until the last row is done
    always_ff @(posedge clk)
    begin
        if (b_go && (b_ctrl_reg.kind == KIND_COMPOSE) && (b_ctrl_reg.row != 2'd3))
        begin
            for (int j = 0; j < DIM; j++)
                tmp_reg[b_ctrl_reg.row[1:0]][j] <= sums[j];
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= (out_valid_reg && !m_axis_tready) ||
                             (b_go && (b_ctrl_reg.kind == KIND_POINT));
    end

    always_ff @(posedge clk)
    begin
        if (b_go && (b_ctrl_reg.kind == KIND_POINT))
            out_data_reg <= sums;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_data_reg[2], out_data_reg[1], out_data_reg[0]};

    // no matrix read in the cycle a translate writes row 3 back
    assert property (@(posedge clk) disable iff (!rst_n)
        (b_go && (b_ctrl_reg.kind == KIND_TRANSLATE)) |-> !a_issue)
        else $error("matrix read while translate write-back pending");

    // compose row counter moves only while a compose sits in the input stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (crow_reg != 2'd0) |-> (a_valid_reg && (a_item_reg.kind == KIND_COMPOSE)))
        else $error("compose row counter out of step");

    // a point held by a full result register stays in the product stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && (b_ctrl_reg.kind == KIND_POINT) && out_valid_reg && !m_axis_tready)
        |=> (b_valid_reg && (b_ctrl_reg.kind == KIND_POINT)))
        else $error("pending point lost");

    // the two writers of the current matrix never collide
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cur_wr_a && cur_wr_b))
        else $error("element write collides with write-back");

endmodule

`default_nettype wire
